// File: rtl/core/tep_pkg.sv
// Package for the task execution profiler: status codes, operations, states,
// request/result payloads and the command/status structs between controller and datapath.
package tep_pkg;

  typedef enum logic [1:0] {
    OP_ENTER = 2'd0,
    OP_EXIT  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DISABLED  = 3'd1,
    ST_UNKNOWN   = 3'd2,
    ST_NEST_FULL = 3'd3,
    ST_NEST_EMPT = 3'd4,
    ST_TBL_FULL  = 3'd5,
    ST_TOT_OVF   = 3'd6,
    ST_PRE_EXC   = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_LOOK = 2'd1,
    CS_EXEC = 2'd2,
    CS_OUT  = 2'd3
  } ctrl_state_e;

  localparam int unsigned CfgIdxW       = 1;
  localparam logic [CfgIdxW-1:0] CFG_TRACE_EN = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_COUNT_DN = 1'b1;
  localparam logic [7:0]  TraceIdLimit  = 8'd254;
  localparam logic [31:0] AllOnes       = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  task_id;
    logic [15:0] timestamp;
    logic [7:0]  overflow_count;
  } event_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] min_period;
    logic [31:0] max_period;
    logic [31:0] avg_period;
    logic [31:0] total_exec;
    logic [31:0] exec_count;
    logic [31:0] min_exec;
    logic [31:0] max_exec;
    logic [31:0] trace_total;
  } metrics_rsp_t;

  typedef struct packed {
    logic load;   // capture request, look up the slot
    logic exec;   // apply the update, build the result
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_sts_t;

endpackage

// File: rtl/core/tep_if.sv
// Valid/ready channel carrying a payload of type T.
// Depends on nothing.
interface tep_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/tep_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module tep_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/core/tep_ctrl.sv
// Controller for the profiler: sequences capture, lookup, update and output.
// Depends on tep_pkg.
module tep_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tep_pkg::dp_cmd_t cmd_o,
  input  tep_pkg::dp_sts_t sts_i
);
  import tep_pkg::*;
  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= CS_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = CS_LOOK;
        end
      end
      CS_LOOK: state_d = CS_EXEC;
      CS_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.done) state_d = CS_OUT;
      end
      CS_OUT: begin
        out_valid_o = 1'b1;
        // take the next request in the same cycle the result leaves
        if (out_ready_i) begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = CS_LOOK;
          end else begin
            state_d = CS_IDLE;
          end
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end
endmodule

// File: rtl/core/tep_dp.sv
// Datapath for the profiler: slot table, per-slot metrics, nesting stack,
// result register. Depends on tep_pkg and tep_ram.
module tep_dp #(
  parameter int unsigned TimerBits = 16,
  parameter int unsigned MaxTasks  = 16,
  parameter int unsigned NestDepth = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tep_pkg::dp_cmd_t cmd_i,
  output tep_pkg::dp_sts_t sts_o,
  input  logic             trace_en_i,
  input  logic             count_dn_i,
  input  logic [1:0]       op_i,
  input  logic [7:0]       id_i,
  input  logic [15:0]      ts_i,
  input  logic [7:0]       ovf_i,
  output logic [2:0]       status_o,
  output logic [31:0]      min_period_o,
  output logic [31:0]      max_period_o,
  output logic [31:0]      avg_period_o,
  output logic [31:0]      total_exec_o,
  output logic [31:0]      exec_count_o,
  output logic [31:0]      min_exec_o,
  output logic [31:0]      max_exec_o,
  output logic [31:0]      trace_total_o
);
  import tep_pkg::*;
  localparam int unsigned SlotW = $clog2(MaxTasks);
  localparam int unsigned CntW  = $clog2(MaxTasks + 1);
  localparam int unsigned NestW = $clog2(NestDepth);
  localparam int unsigned LvlW  = $clog2(NestDepth + 1);

  // captured request
  logic [1:0]           op_q;
  logic [7:0]           id_q;
  logic [TimerBits-1:0] ts_q;
  logic [7:0]           ovf_q;

  // slot map: memory of slot numbers with per-id valid bits
  logic [255:0]     sv_q;
  logic [SlotW-1:0] map_rd;
  logic             map_we;
  logic [SlotW-1:0] map_wd;
  logic [CntW-1:0]  used_q;
  logic             hit_q;

  // hold the captured id on the address so the read data stays valid
  tep_ram #(.Width(SlotW), .Depth(256)) u_map (
    .clk_i, .we_i(map_we), .addr_i(cmd_i.load ? id_i : id_q), .wdata_i(map_wd),
    .rdata_o(map_rd)
  );

  // per-slot metrics (flip-flops, reset values given)
  logic [31:0] pmin_q [MaxTasks];
  logic [31:0] pmax_q [MaxTasks];
  logic [31:0] pavg_q [MaxTasks];
  logic [31:0] etot_q [MaxTasks];
  logic [31:0] erun_q [MaxTasks];
  logic [31:0] emin_q [MaxTasks];
  logic [31:0] emax_q [MaxTasks];
  logic [TimerBits-1:0] lts_q [MaxTasks];
  logic [7:0]  lovf_q [MaxTasks];

  // nesting stack
  logic [SlotW-1:0]     ftask_q [NestDepth];
  logic [TimerBits-1:0] fstart_q [NestDepth];
  logic [31:0]          fpre_q  [NestDepth];
  logic [LvlW-1:0]      lvl_q;
  logic [31:0]          grand_q;

  logic [2:0]  st_q;
  logic [31:0] r_q [8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hit_q <= 1'b0;
    else if (cmd_i.load) hit_q <= (id_i <= TraceIdLimit) && sv_q[id_i];
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      id_q  <= id_i;
      ts_q  <= TimerBits'(ts_i);
      ovf_q <= ovf_i;
    end
  end

  // enter path
  logic [SlotW-1:0] ent_s, top_s, sel_s;
  logic [NestW-1:0] top_i, push_i, par_i;
  logic [TimerBits-1:0] lts;
  logic [7:0]  dovf;
  logic        wrapped;
  logic [TimerBits:0] pd;
  logic [31:0] per;
  logic [32:0] psum;

  assign ent_s  = hit_q ? map_rd : used_q[SlotW-1:0];
  assign push_i = lvl_q[NestW-1:0];
  assign top_i  = NestW'(lvl_q - LvlW'(1));
  assign par_i  = NestW'(lvl_q - LvlW'(2));
  assign top_s  = ftask_q[top_i];
  assign lts    = lts_q[ent_s];
  assign wrapped = count_dn_i ? (ts_q > lts) : (ts_q < lts);
  always_comb begin
    dovf = ovf_q - lovf_q[ent_s];
    if (wrapped && dovf != 8'd0) dovf = dovf - 8'd1;
    // modulo the timer range the wrapped and plain differences coincide
    pd = count_dn_i ? {1'b0, lts} - {1'b0, ts_q} : {1'b0, ts_q} - {1'b0, lts};
    if (wrapped) pd[TimerBits] = 1'b0;
    per  = 32'({dovf, {TimerBits{1'b0}}}) + 32'(pd[TimerBits-1:0]);
    psum = {1'b0, pavg_q[ent_s]} + {1'b0, per};
  end

  // exit path
  logic [TimerBits-1:0] tdiff;
  logic [31:0] tot, pre, net;
  logic [32:0] eacc, pacc;
  always_comb begin
    tdiff = count_dn_i ? fstart_q[top_i] - ts_q : ts_q - fstart_q[top_i];
    tot   = 32'(tdiff);
    pre   = fpre_q[top_i];
    net   = (pre > tot) ? 32'd0 : tot - pre;
    eacc  = {1'b0, etot_q[top_s]} + {1'b0, net};
    pacc  = {1'b0, fpre_q[par_i]} + {1'b0, tot};
  end

  logic en_ok, ex_ok, rd_ok;
  logic [2:0] st_d;
  always_comb begin
    en_ok = 1'b0; ex_ok = 1'b0; rd_ok = 1'b0; map_we = 1'b0;
    st_d = ST_OK;
    case (op_e'(op_q))
      OP_ENTER: begin
        if (!trace_en_i) st_d = ST_DISABLED;
        else if (id_q > TraceIdLimit) st_d = ST_UNKNOWN;
        else if (lvl_q >= LvlW'(NestDepth)) st_d = ST_NEST_FULL;
        else if (!hit_q && used_q >= CntW'(MaxTasks)) st_d = ST_TBL_FULL;
        else begin
          en_ok  = cmd_i.exec;
          map_we = cmd_i.exec && !hit_q;
        end
      end
      OP_EXIT: begin
        if (!trace_en_i) st_d = ST_DISABLED;
        else if (lvl_q == '0) st_d = ST_NEST_EMPT;
        else begin
          ex_ok = cmd_i.exec;
          if (pre > tot) st_d = ST_PRE_EXC;
          else if (eacc[32]) st_d = ST_TOT_OVF;
        end
      end
      OP_READ: begin
        if (!hit_q) st_d = ST_UNKNOWN;
        else rd_ok = 1'b1;
      end
      default: st_d = ST_OK;
    endcase
  end
  assign map_wd = used_q[SlotW-1:0];
  assign sel_s  = map_rd;
  assign sts_o.done = cmd_i.exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0; used_q <= '0; lvl_q <= '0; grand_q <= '0;
      for (int i = 0; i < MaxTasks; i++) begin
        pmin_q[i] <= AllOnes; pmax_q[i] <= '0; pavg_q[i] <= AllOnes;
        etot_q[i] <= '0; erun_q[i] <= '0; emin_q[i] <= AllOnes;
        emax_q[i] <= '0; lts_q[i] <= '0; lovf_q[i] <= '0;
      end
    end else begin
      if (en_ok) begin
        if (!hit_q) begin
          sv_q[id_q] <= 1'b1;
          used_q     <= used_q + CntW'(1);
        end else begin
          if (per < pmin_q[ent_s]) pmin_q[ent_s] <= per;
          if (per > pmax_q[ent_s]) pmax_q[ent_s] <= per;
          pavg_q[ent_s] <= (pavg_q[ent_s] == AllOnes) ? per : psum[32:1];
        end
        lts_q[ent_s]  <= ts_q;
        lovf_q[ent_s] <= ovf_q;
        lvl_q         <= lvl_q + LvlW'(1);
      end
      if (ex_ok) begin
        lvl_q <= lvl_q - LvlW'(1);
        if (net < emin_q[top_s]) emin_q[top_s] <= net;
        if (net > emax_q[top_s]) emax_q[top_s] <= net;
        if (!eacc[32]) begin
          etot_q[top_s] <= eacc[31:0];
          erun_q[top_s] <= erun_q[top_s] + 32'd1;
        end
        if (lvl_q == LvlW'(1)) grand_q <= grand_q + tot;
      end
    end
  end

  // stack entries and result need no reset
  always_ff @(posedge clk_i) begin
    if (en_ok) begin
      ftask_q[push_i]  <= ent_s;
      fstart_q[push_i] <= ts_q;
      fpre_q[push_i]   <= '0;
    end
    if (ex_ok && lvl_q > LvlW'(1)) fpre_q[par_i] <= pacc[32] ? AllOnes : pacc[31:0];
    if (cmd_i.exec) begin
      st_q   <= st_d;
      r_q[0] <= rd_ok ? pmin_q[sel_s] : '0;
      r_q[1] <= rd_ok ? pmax_q[sel_s] : '0;
      r_q[2] <= rd_ok ? pavg_q[sel_s] : '0;
      r_q[3] <= rd_ok ? etot_q[sel_s] : '0;
      r_q[4] <= rd_ok ? erun_q[sel_s] : '0;
      r_q[5] <= rd_ok ? emin_q[sel_s] : '0;
      r_q[6] <= rd_ok ? emax_q[sel_s] : '0;
      r_q[7] <= rd_ok ? grand_q : '0;
    end
  end

  assign status_o      = st_q;
  assign min_period_o  = r_q[0];
  assign max_period_o  = r_q[1];
  assign avg_period_o  = r_q[2];
  assign total_exec_o  = r_q[3];
  assign exec_count_o  = r_q[4];
  assign min_exec_o    = r_q[5];
  assign max_exec_o    = r_q[6];
  assign trace_total_o = r_q[7];
endmodule

// File: rtl/core/task_execution_profiler.sv
// Task execution profiler: per-task call period and net execution statistics.
// Depends on tep_pkg, tep_if, tep_ctrl, tep_dp, tep_ram.
//
// Usage:
//   req_i carries requests: enter (0), exit (1) or read metrics (2) of a
//   task id, with a timer stamp and an overflow count. rsp_o returns one
//   result per request: a status code and, for a successful read, the
//   task's metrics and the grand total (all zero otherwise).
//   Configuration: cfg_we_i/cfg_idx_i/cfg_wdata_i write trace enable (0)
//   and timer direction (1); write only while the block is idle.
// Sequence:
//   A request is captured when taken, the slot map memory is read in
//   CS_LOOK, the metrics are updated and the result registered in
//   CS_EXEC, and the result shows in CS_OUT. A new request is accepted
//   in the cycle the result is taken, so the block takes no new request
//   before the last result leaves.
// Reset:
//   Clears the slot valid bits, metrics, nest level and grand total at once.
// Stall:
//   While rsp_o.ready is low the result holds and no request is taken.
module task_execution_profiler #(
  parameter int unsigned TIMER_BITS = 16,
  parameter int unsigned MAX_TASKS  = 16,
  parameter int unsigned NEST_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tep_if.sink        req_i,
  tep_if.source      rsp_o,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [0:0] cfg_wdata_i
);
  import tep_pkg::*;

  logic trace_en_q, count_dn_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trace_en_q <= 1'b0;
      count_dn_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TRACE_EN) trace_en_q <= cfg_wdata_i[0];
      if (cfg_idx_i == CFG_COUNT_DN) count_dn_q <= cfg_wdata_i[0];
    end
  end

  tep_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req_i.valid), .in_ready_o(req_i.ready),
    .out_valid_o(rsp_o.valid), .out_ready_i(rsp_o.ready),
    .cmd_o(cmd), .sts_i(sts)
  );

  tep_dp #(.TimerBits(TIMER_BITS), .MaxTasks(MAX_TASKS), .NestDepth(NEST_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .trace_en_i(trace_en_q), .count_dn_i(count_dn_q),
    .op_i(req_i.data.operation), .id_i(req_i.data.task_id),
    .ts_i(req_i.data.timestamp), .ovf_i(req_i.data.overflow_count),
    .status_o(rsp_o.data.status),
    .min_period_o(rsp_o.data.min_period), .max_period_o(rsp_o.data.max_period),
    .avg_period_o(rsp_o.data.avg_period), .total_exec_o(rsp_o.data.total_exec),
    .exec_count_o(rsp_o.data.exec_count), .min_exec_o(rsp_o.data.min_exec),
    .max_exec_o(rsp_o.data.max_exec), .trace_total_o(rsp_o.data.trace_total)
  );
endmodule

// File: rtl/core/tep_checker.sv
// Port-level checker for the profiler, bound to the top level.
// Depends on the top level's port names only.
module tep_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status
);
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |-> !in_ready) else $error("request taken during stall");
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  a_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> ##2 out_valid) else $error("result missing");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(status))) else $error("result dropped");
endmodule

bind task_execution_profiler tep_checker u_tep_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(req_i.valid), .in_ready(req_i.ready),
  .out_valid(rsp_o.valid), .out_ready(rsp_o.ready),
  .status(rsp_o.data.status)
);

// File: tb/sv/tb_task_execution_profiler.sv
// Testbench for task_execution_profiler: drives enter, exit and read requests,
// predicts each result in a scoreboard class and compares it field by field.
// Depends on tep_pkg, tep_if and the profiler RTL.
`timescale 1ns / 1ps

module tb_task_execution_profiler;
  import tep_pkg::*;

  localparam int unsigned NumSlots  = 16;
  localparam int unsigned NestMax   = 8;
  localparam int unsigned CycleLimit = 600000;

  class profile_scoreboard;
    bit          tracing;
    bit          down;
    bit          has_slot[256];
    logic [4:0]  slot_map[256];
    int unsigned used;
    logic [31:0] pmin[NumSlots], pmax[NumSlots], pavg[NumSlots];
    logic [31:0] etot[NumSlots], eruns[NumSlots], emin[NumSlots], emax[NumSlots];
    logic [15:0] lstamp[NumSlots];
    logic [7:0]  lovf[NumSlots];
    logic [4:0]  fr_slot[NestMax];
    logic [15:0] fr_start[NestMax];
    logic [31:0] fr_pre[NestMax];
    int unsigned depth;
    logic [31:0] grand;
    metrics_rsp_t expected_q[$];
    int unsigned errors;
    int unsigned results_seen;
    int unsigned status_seen[8];

    function new();
      for (int i = 0; i < 256; i++) has_slot[i] = 0;
      for (int i = 0; i < NumSlots; i++) begin
        pmin[i] = AllOnes; pmax[i] = 0; pavg[i] = AllOnes;
        etot[i] = 0; eruns[i] = 0; emin[i] = AllOnes; emax[i] = 0;
        lstamp[i] = 0; lovf[i] = 0;
      end
      used = 0; depth = 0; grand = 0; tracing = 0; down = 0; errors = 0;
      results_seen = 0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
    endfunction

    function logic [31:0] call_period(int s, logic [15:0] ts, logic [7:0] ovf);
      longint unsigned diff, last, p, t;
      bit wrapped;
      diff = 64'(8'(ovf - lovf[s]));
      last = lstamp[s];
      t = ts;
      wrapped = down ? (t > last) : (t < last);
      if (wrapped) begin
        if (diff > 0) diff--;
        p = down ? (65536 + last - t) : (65536 + t - last);
      end else begin
        p = down ? (last - t) : (t - last);
      end
      p += diff << 16;
      return p[31:0];
    endfunction

    function status_e enter_task(logic [7:0] id, logic [15:0] ts, logic [7:0] ovf);
      int s;
      logic [31:0] p;
      logic [32:0] sum;
      if (id > TraceIdLimit) return ST_UNKNOWN;
      if (depth >= NestMax) return ST_NEST_FULL;
      if (!has_slot[id]) begin
        if (used >= NumSlots) return ST_TBL_FULL;
        s = used;
        has_slot[id] = 1;
        slot_map[id] = 5'(s);
        used++;
      end else begin
        s = slot_map[id] % NumSlots;
        p = call_period(s, ts, ovf);
        if (p < pmin[s]) pmin[s] = p;
        if (p > pmax[s]) pmax[s] = p;
        if (pavg[s] == AllOnes) pavg[s] = p;
        else begin
          sum = {1'b0, pavg[s]} + {1'b0, p};
          pavg[s] = sum[32:1];
        end
      end
      lstamp[s] = ts;
      lovf[s] = ovf;
      fr_slot[depth] = 5'(s);
      fr_start[depth] = ts;
      fr_pre[depth] = 0;
      depth++;
      return ST_OK;
    endfunction

    function status_e exit_task(logic [15:0] ts);
      status_e st;
      int s;
      logic [31:0] elapsed, pre, net;
      logic [32:0] acc;
      st = ST_OK;
      if (depth == 0) return ST_NEST_EMPT;
      depth--;
      s = fr_slot[depth] % NumSlots;
      elapsed = down ? 32'(16'(fr_start[depth] - ts)) : 32'(16'(ts - fr_start[depth]));
      pre = fr_pre[depth];
      if (pre > elapsed) begin
        net = 0;
        st = ST_PRE_EXC;
      end else begin
        net = elapsed - pre;
      end
      if (net < emin[s]) emin[s] = net;
      if (net > emax[s]) emax[s] = net;
      acc = {1'b0, etot[s]} + {1'b0, net};
      if (!acc[32]) begin
        etot[s] = acc[31:0];
        eruns[s]++;
      end else if (st == ST_OK) begin
        st = ST_TOT_OVF;
      end
      if (depth > 0) begin
        acc = {1'b0, fr_pre[depth-1]} + {1'b0, elapsed};
        fr_pre[depth-1] = acc[32] ? AllOnes : acc[31:0];
      end else begin
        grand += elapsed;
      end
      return st;
    endfunction

    // Predict the result of one accepted request and queue it.
    function void note_request(event_req_t r);
      metrics_rsp_t e;
      int s;
      e = '0;
      e.status = ST_OK;
      if (r.operation == OP_ENTER || r.operation == OP_EXIT) begin
        if (!tracing) e.status = ST_DISABLED;
        else if (r.operation == OP_ENTER)
          e.status = enter_task(r.task_id, r.timestamp, r.overflow_count);
        else e.status = exit_task(r.timestamp);
      end else if (r.operation == OP_READ) begin
        if (r.task_id > TraceIdLimit || !has_slot[r.task_id]) e.status = ST_UNKNOWN;
        else begin
          s = slot_map[r.task_id] % NumSlots;
          e.min_period = pmin[s];  e.max_period = pmax[s];
          e.avg_period = pavg[s];  e.total_exec = etot[s];
          e.exec_count = eruns[s]; e.min_exec   = emin[s];
          e.max_exec   = emax[s];  e.trace_total = grand;
        end
      end
      expected_q.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0h, want %0h", what, got, want);
      errors++;
    endtask

    task check_result(metrics_rsp_t r);
      metrics_rsp_t e;
      logic [31:0] got[8], want[8];
      string names[8];
      if (expected_q.size() == 0) begin
        report("unexpected result status", 32'(r.status), 0);
        return;
      end
      e = expected_q.pop_front();
      results_seen++;
      status_seen[e.status]++;
      names = '{"min_period", "max_period", "avg_period", "total_exec",
                "exec_count", "min_exec", "max_exec", "trace_total"};
      got  = '{r.min_period, r.max_period, r.avg_period, r.total_exec,
               r.exec_count, r.min_exec, r.max_exec, r.trace_total};
      want = '{e.min_period, e.max_period, e.avg_period, e.total_exec,
               e.exec_count, e.min_exec, e.max_exec, e.trace_total};
      if (r.status !== e.status) report("status", 32'(r.status), 32'(e.status));
      for (int i = 0; i < 8; i++)
        if (got[i] !== want[i]) report(names[i], got[i], want[i]);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [0:0] cfg_wdata_i;

  tep_if #(.T(event_req_t))   req_if ();
  tep_if #(.T(metrics_rsp_t)) rsp_if ();

  task_execution_profiler DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  profile_scoreboard sb;
  int unsigned tx_idle;
  int unsigned rx_idle;
  int unsigned cycles;
  int unsigned sent;
  logic [31:0] now;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stalls, sample between edges.
  always @(posedge clk_i) begin
    rsp_if.ready <= rst_ni && ($urandom_range(99) >= rx_idle);
  end

  always @(negedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
  end

  task write_cfg(logic [0:0] idx, logic [0:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TRACE_EN) sb.tracing = val;
    else sb.down = val;
  endtask

  task drain();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task send_request(op_e op, logic [7:0] id, logic [15:0] ts, logic [7:0] ovf);
    event_req_t r;
    bit taken;
    r.operation = op; r.task_id = id; r.timestamp = ts; r.overflow_count = ovf;
    if ($urandom_range(99) < tx_idle) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do begin
      @(negedge clk_i);
      taken = req_if.ready;
      @(posedge clk_i);
    end while (!taken);
    sb.note_request(r);
    sent++;
  endtask

  task stop_requests();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Advance the modeled timer and send an event stamped with it.
  task timed_request(op_e op, logic [7:0] id, int unsigned step);
    logic [15:0] ts;
    now += step;
    ts = sb.down ? ~now[15:0] : now[15:0];
    send_request(op, id, ts, now[23:16]);
  endtask

  function logic [7:0] pick_task();
    logic [7:0] id;
    if ($urandom_range(99) < 85) begin
      id = 8'($urandom_range(0, 19));
      if (id == 8'd19) id = TraceIdLimit;
    end else begin
      id = 8'($urandom_range(0, 255));
    end
    return id;
  endfunction

  task random_phase(int unsigned count);
    int unsigned k;
    op_e op;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < 10) begin
        send_request(op_e'($urandom_range(0, 3)), 8'($urandom),
                     16'($urandom), 8'($urandom));
      end else if ($urandom_range(99) < 15) begin
        timed_request(OP_READ, pick_task(), $urandom_range(0, 50));
      end else begin
        if (sb.depth == 0) op = OP_ENTER;
        else if (sb.depth >= NestMax) op = ($urandom_range(9) == 0) ? OP_ENTER : OP_EXIT;
        else op = ($urandom_range(99) < 50) ? OP_ENTER : OP_EXIT;
        timed_request(op, pick_task(),
                      ($urandom_range(99) < 8) ? $urandom_range(0, 1 << 21)
                                               : $urandom_range(1, 3000));
      end
    end
    stop_requests();
    drain();
  endtask

  initial begin
    sb = new();
    cycles = 0; sent = 0; now = 0;
    tx_idle = 6; rx_idle = 58;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    req_if.valid = 1'b0; req_if.data = '0;
    rsp_if.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Tracing off: events rejected, reads still answer.
    write_cfg(CFG_TRACE_EN, 1'b0);
    write_cfg(CFG_COUNT_DN, 1'b0);
    send_request(OP_ENTER, 8'd3, 16'h0010, 8'h00);
    send_request(OP_EXIT, 8'd3, 16'h0020, 8'h00);
    send_request(OP_READ, 8'd255, 16'h0, 8'h0);
    send_request(OP_READ, 8'd0, 16'h0, 8'h0);
    send_request(OP_NONE, 8'hFF, 16'hFFFF, 8'hFF);
    stop_requests();
    drain();

    write_cfg(CFG_TRACE_EN, 1'b1);
    send_request(OP_EXIT, 8'd0, 16'h0, 8'h0);
    send_request(OP_ENTER, 8'd255, 16'h0, 8'h0);
    send_request(OP_ENTER, 8'd0, 16'h0000, 8'h00);
    send_request(OP_ENTER, TraceIdLimit, 16'hFFFF, 8'hFF);
    send_request(OP_EXIT, 8'd7, 16'h0005, 8'h00);
    send_request(OP_EXIT, 8'd7, 16'h0003, 8'h01);
    send_request(OP_ENTER, 8'd0, 16'h1234, 8'h02);
    send_request(OP_ENTER, TraceIdLimit, 16'h0001, 8'h00);
    send_request(OP_READ, TraceIdLimit, 16'h0, 8'h0);
    // Fill the nest, then two more enters are refused.
    for (int i = 1; i <= 7; i++) timed_request(OP_ENTER, 8'(i), 40);
    timed_request(OP_ENTER, 8'd9, 40);
    for (int i = 0; i < 8; i++) timed_request(OP_EXIT, 8'd0, 25);
    // Take more slots in the table; the next new task still gets one.
    for (int i = 10; i <= 15; i++) timed_request(OP_ENTER, 8'(i), 10);
    timed_request(OP_ENTER, 8'd16, 10);
    for (int i = 0; i < 6; i++) timed_request(OP_EXIT, 8'd0, 10);
    timed_request(OP_READ, 8'd0, 0);
    stop_requests();
    drain();

    random_phase(380);
    tx_idle = 58; rx_idle = 6;
    write_cfg(CFG_COUNT_DN, 1'b1);
    random_phase(380);
    tx_idle = 0; rx_idle = 0;
    write_cfg(CFG_COUNT_DN, 1'b0);
    random_phase(360);

    $display("%0d requests sent, %0d results checked in %0d cycles", sent,
             sb.results_seen, cycles);
    $display("status counts ok/dis/unk/nfull/nempty/tfull/ovf/pre: %0d %0d %0d %0d %0d %0d %0d %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4], sb.status_seen[5], sb.status_seen[6], sb.status_seen[7]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/tep_pkg.sv
rtl/core/tep_if.sv
rtl/core/tep_ram.sv
rtl/core/tep_ctrl.sv
rtl/core/tep_dp.sv
rtl/core/task_execution_profiler.sv
rtl/core/tep_checker.sv
tb/sv/tb_task_execution_profiler.sv
